FILE: rtl/core/double_ended_queue_core_defines.svh
// Assertion macros used by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/dq_pkg.sv
// Package with the request codes, status codes and shared types of the queue.
`timescale 1ns / 1ps

package dq_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } dq_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } dq_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } dq_state_type;

   typedef struct packed {
      logic                 load;
      logic                 from_ram;
      dq_status_type        status;
      logic [COUNT_W-1:0]   entry_count;
      logic                 is_empty;
   } dq_load_type;

endpackage

FILE: rtl/core/dq_ram.sv
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps

module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dq_ctrl.sv
// Front pointer, count and sequencing of the memory accesses for each request.
`timescale 1ns / 1ps

module dq_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  dq_pkg::dq_op_type        req_op,
   input  logic                     rsp_free,
   output logic                     req_ready,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   output dq_pkg::dq_load_type      load
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   dq_pkg::dq_state_type state_ff, state_in;
   logic [AW-1:0]        front_ff, front_in;
   logic [CW-1:0]        count_ff, count_in;

   logic          accept;
   logic          full;
   logic          empty;
   logic [AW-1:0] front_dec;
   logic [AW-1:0] front_inc;
   logic [SW-1:0] back_sum;
   logic [SW-1:0] last_sum;
   logic [AW-1:0] back_slot;
   logic [AW-1:0] last_slot;
   logic          pop_ok;

   assign req_ready = (state_ff == dq_pkg::S_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign back_sum  = SW'(front_ff) + SW'(count_ff);
   assign last_sum  = back_sum - SW'(1);
   assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
   assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::S_IDLE: begin
            if (accept && pop_ok) begin
               state_in = dq_pkg::S_READ;
            end
         end
         dq_pkg::S_READ: begin
            state_in = dq_pkg::S_IDLE;
         end
         default: begin
            state_in = dq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      logic [dq_pkg::COUNT_W+CW-1:0] count_wide;
      front_in         = front_ff;
      count_in         = count_ff;
      wr_en            = 1'b0;
      wr_addr          = back_slot;
      rd_en            = 1'b0;
      rd_addr          = front_ff;
      pop_ok           = 1'b0;
      load.load        = 1'b0;
      load.from_ram    = 1'b0;
      load.status      = dq_pkg::ST_OK;
      unique case (req_op)
         dq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               load.status = dq_pkg::ST_FULL;
            end else begin
               wr_en    = accept;
               wr_addr  = front_dec;
               front_in = accept ? front_dec : front_ff;
               count_in = accept ? count_ff + CW'(1) : count_ff;
            end
         end
         dq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               load.status = dq_pkg::ST_FULL;
            end else begin
               wr_en    = accept;
               wr_addr  = back_slot;
               count_in = accept ? count_ff + CW'(1) : count_ff;
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               load.status = dq_pkg::ST_EMPTY;
            end else begin
               pop_ok   = 1'b1;
               rd_en    = accept;
               rd_addr  = front_ff;
               front_in = accept ? front_inc : front_ff;
               count_in = accept ? count_ff - CW'(1) : count_ff;
            end
         end
         dq_pkg::OP_POP_BACK: begin
            if (empty) begin
               load.status = dq_pkg::ST_EMPTY;
            end else begin
               pop_ok   = 1'b1;
               rd_en    = accept;
               rd_addr  = last_slot;
               count_in = accept ? count_ff - CW'(1) : count_ff;
            end
         end
         default: begin
            load.status = dq_pkg::ST_OK;
         end
      endcase

      if (state_ff == dq_pkg::S_READ) begin
         load.load     = 1'b1;
         load.from_ram = 1'b1;
         load.status   = dq_pkg::ST_OK;
         count_wide    = {{dq_pkg::COUNT_W{1'b0}}, count_ff};
         load.is_empty = (count_ff == '0);
      end else begin
         load.load     = accept && !pop_ok;
         count_wide    = {{dq_pkg::COUNT_W{1'b0}}, count_in};
         load.is_empty = (count_in == '0);
      end
      load.entry_count = count_wide[dq_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/double_ended_queue_core.sv
// Top level of the double-ended queue: word memory, control and result register.
//
//   Channel   Direction   Moves
//   req_*     in          one request: operation in tuser, pushed word in tdata
//   rsp_*     out         one result: status in tuser, popped word and count in tdata
//
// A push or a refused request loads the result register directly; a successful pop
// first reads the word memory through its registered read port, holding off requests.
// Reset clears the front pointer, the count and the result valid; the word
// memory is not cleared, since a pop only reads words that a push wrote.
// A held result stalls new requests only when it is not taken in that cycle.
`timescale 1ns / 1ps

module double_ended_queue_core #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] pop_value, [38:32] entry_count, [39] is_empty
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW = $clog2(DEPTH);

   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic                              rd_en;
   logic [AW-1:0]                     rd_addr;
   logic [dq_pkg::VALUE_W-1:0]        rd_data;
   logic                              rsp_free;
   dq_pkg::dq_load_type               load;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dq_pkg::VALUE_W-1:0]        rsp_value_ff;
   dq_pkg::dq_status_type             rsp_status_ff;
   logic [dq_pkg::COUNT_W-1:0]        rsp_count_ff;
   logic                              rsp_empty_ff;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   dq_ram #(
      .WIDTH (dq_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_dq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dq_ctrl #(
      .DEPTH (DEPTH)
   ) u_dq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (dq_pkg::dq_op_type'(req_tuser)),
      .rsp_free  (rsp_free),
      .req_ready (req_tready),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .load      (load)
   );

   always_comb begin
      if (load.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         rsp_value_ff  <= load.from_ram ? rd_data : '0;
         rsp_status_ff <= load.status;
         rsp_count_ff  <= load.entry_count;
         rsp_empty_ff  <= load.is_empty;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_empty_ff, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: rtl/core/dq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
`include "double_ended_queue_core_defines.svh"

module dq_checker #(
   parameter int DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic req_seen;

   assign req_seen = req_tvalid && req_tready && (req_tdata == req_tdata) &&
                     (req_tuser == req_tuser);

   `DQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled result changed.")
   `DQ_ASSERT_NOW(a_empty_refusal, rsp_tvalid && (rsp_tuser == dq_pkg::ST_EMPTY), rsp_tdata[39] && (rsp_tdata[38:32] == 7'd0) && (rsp_tdata[31:0] == 32'd0), "Refused pop must report an empty queue and a zero word.")
   `DQ_ASSERT_NOW(a_full_refusal, rsp_tvalid && (rsp_tuser == dq_pkg::ST_FULL), !rsp_tdata[39] && (rsp_tdata[31:0] == 32'd0), "Refused push must report a nonempty queue and a zero word.")
   `DQ_ASSERT_NOW(a_count_bound, rsp_tvalid, (DEPTH > 127) || (rsp_tdata[38:32] <= 7'(DEPTH)), "Reported count exceeds the queue depth.")
   `DQ_ASSERT_NOW(a_empty_flag, rsp_tvalid || req_seen, !rsp_tvalid || (rsp_tdata[39] == (rsp_tdata[38:32] == 7'd0)) || (DEPTH > 127), "Empty flag disagrees with the count.")

endmodule

bind double_ended_queue_core dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
